>>> hdl/mecanum_drive_step_period_framer_defines.svh
// assertion macros for the mecanum drive framer
`ifndef MECANUM_DRIVE_STEP_PERIOD_FRAMER_DEFINES_SVH
`define MECANUM_DRIVE_STEP_PERIOD_FRAMER_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define MDF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define MDF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> hdl/mdsp_pkg.sv
// shared types, constants and functions for the mecanum drive framer
`timescale 1ns / 1ps
`default_nettype none
package mdsp_pkg;
  localparam int unsigned AtanLen = 24;
  localparam logic [31:0] QuarterTurn = 32'h4000_0000;
  localparam logic [31:0] EighthTurn = 32'h2000_0000;
  localparam logic [16:0] InvGain = 17'd39797;
  localparam logic [15:0] StopCode = 16'hFFFF;
  localparam logic [7:0] FlagBase = 8'hA0;
  localparam logic [15:0] OneQ15 = 16'd32768;

  typedef enum logic [1:0] {
    REG_TRANS_DZ = 2'd0,
    REG_TURN_DZ = 2'd1,
    REG_FAST = 2'd2,
    REG_SLOW = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [14:0] trans_dz;
    logic [14:0] turn_dz;
    logic [15:0] fast;
    logic [15:0] slow;
  } cfg_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0: r = 32'h20000000; 5'd1: r = 32'h12E4051E; 5'd2: r = 32'h09FB385B;
      5'd3: r = 32'h051111D4; 5'd4: r = 32'h028B0D43; 5'd5: r = 32'h0145D7E1;
      5'd6: r = 32'h00A2F61E; 5'd7: r = 32'h00517C55; 5'd8: r = 32'h0028BE53;
      5'd9: r = 32'h00145F2F; 5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3; 5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517C; 5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F; 5'd19: r = 32'h00000517; 5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000145; 5'd22: r = 32'h000000A2; 5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

>>> hdl/mdsp_cordic_stage.sv
// one registered cordic micro-rotation step with handshake
`timescale 1ns / 1ps
`default_nettype none
module mdsp_cordic_stage #(
  parameter int unsigned Shift = 0,
  parameter int unsigned Width = 27,
  parameter int unsigned SideW = 1,
  parameter bit Rotate = 1'b0
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire logic [Width-1:0] x_i,
  input  wire logic [Width-1:0] y_i,
  input  wire logic [31:0]      z_i,
  input  wire logic [SideW-1:0] side_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output logic [Width-1:0]      x_o,
  output logic [Width-1:0]      y_o,
  output logic [31:0]           z_o,
  output logic [SideW-1:0]      side_o
);
  import mdsp_pkg::*;
  logic             valid_q;
  logic [Width-1:0] x_q, y_q, x_d, y_d, xs, ys;
  logic [31:0]      z_q, z_d, a;
  logic [SideW-1:0] side_q;
  logic             dir;

  assign ready_o = !valid_q || ready_i;
  assign a = atan_lut(5'(Shift));
  assign xs = Width'($signed(x_i) >>> Shift);
  assign ys = Width'($signed(y_i) >>> Shift);
  assign dir = Rotate ? !z_i[31] : !y_i[Width-1];

  always_comb begin
    if (Rotate == dir) begin
      x_d = Rotate ? x_i - ys : x_i - ys;
      y_d = y_i + xs;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
    end
    if (Rotate) z_d = dir ? z_i - a : z_i + a;
    else z_d = dir ? z_i + a : z_i - a;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
      side_q <= side_i;
    end
  end
  assign valid_o = valid_q;
  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
  assign side_o = side_q;
endmodule
`default_nettype wire

>>> hdl/mdsp_period_div.sv
// pipelined restoring divider for one wheel step period or stick scale
`timescale 1ns / 1ps
`default_nettype none
module mdsp_period_div #(
  parameter int unsigned SideW = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire logic [47:0]      num_i,
  input  wire logic [32:0]      den_i,
  input  wire logic [SideW-1:0] side_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output logic [47:0]           quo_o,
  output logic [SideW-1:0]      side_o
);
  localparam int unsigned Bits = 48;
  localparam int unsigned PerStg = 4;
  localparam int unsigned Stg = Bits / PerStg;
  logic [Stg:0]             vld;
  logic [Stg:0]             rdy;
  logic [Stg:0][47:0]       n;
  logic [Stg:0][33:0]       rm;
  logic [Stg:0][32:0]       dv;
  logic [Stg:0][SideW-1:0]  sd;

  assign vld[0] = valid_i;
  assign ready_o = rdy[0];
  assign n[0] = num_i;
  assign rm[0] = '0;
  assign dv[0] = den_i;
  assign sd[0] = side_i;

  for (genvar g = 0; g < Stg; g++) begin : g_stg
    logic              v_q;
    logic [47:0]       n_q, n_d;
    logic [33:0]       r_q, r_d;
    logic [32:0]       d_q;
    logic [SideW-1:0]  s_q;
    always_comb begin
      logic [34:0] t;
      n_d = n[g];
      r_d = rm[g];
      for (int b = 0; b < PerStg; b++) begin
        t = {r_d, n_d[47]};
        n_d = {n_d[46:0], 1'b0};
        if (t >= {2'b0, dv[g]}) begin
          t = t - {2'b0, dv[g]};
          n_d[0] = 1'b1;
        end
        r_d = t[33:0];
      end
    end
    assign rdy[g] = !v_q || rdy[g+1];
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (rdy[g]) begin
        v_q <= vld[g];
      end
    end
    always_ff @(posedge clk_i) begin
      if (rdy[g] && vld[g]) begin
        n_q <= n_d;
        r_q <= r_d;
        d_q <= dv[g];
        s_q <= sd[g];
      end
    end
    assign vld[g+1] = v_q;
    assign n[g+1] = n_q;
    assign rm[g+1] = r_q;
    assign dv[g+1] = d_q;
    assign sd[g+1] = s_q;
  end
  assign rdy[Stg] = ready_i;
  assign valid_o = vld[Stg];
  assign quo_o = n[Stg];
  assign side_o = sd[Stg];
endmodule
`default_nettype wire

>>> hdl/mdsp_framer.sv
// frame serializer: periods and directions to twelve bytes
`timescale 1ns / 1ps
`default_nettype none
module mdsp_framer (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  output logic                ready_o,
  input  wire logic [63:0]    per_i,
  input  wire logic [3:0]     dir_i,
  output logic                valid_o,
  input  wire logic           ready_i,
  output logic [7:0]          byte_o,
  output logic                last_o
);
  import mdsp_pkg::*;
  logic [3:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [11:0][7:0] fr_q;
  logic [11:0][7:0] fr_d;
  logic             take, pop;

  assign pop = busy_q && ready_i;
  assign take = valid_i && ready_o;
  assign ready_o = !busy_q || (pop && cnt_q == 4'd11);

  always_comb begin
    logic [7:0] ck;
    fr_d[0] = 8'h0;
    fr_d[1] = 8'h0;
    fr_d[2] = FlagBase | {4'h0, dir_i};
    for (int k = 0; k < 8; k++) fr_d[3+k] = per_i[8*k +: 8];
    ck = '0;
    for (int k = 2; k < 11; k++) ck = ck ^ fr_d[k];
    fr_d[11] = ck;
    busy_d = busy_q;
    cnt_d = cnt_q;
    if (pop) begin
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'd11) busy_d = 1'b0;
    end
    if (take) begin
      busy_d = 1'b1;
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    if (take) fr_q <= fr_d;
  end
  assign valid_o = busy_q;
  assign byte_o = fr_q[cnt_q];
  assign last_o = cnt_q == 4'd11;
endmodule
`default_nettype wire

>>> hdl/mecanum_drive_step_period_framer.sv
// top level: stick sample to mecanum step-period frame
// channel | dir | tdata                               | tlast
// s_axis  | in  | stick_x[15:0] stick_y[31:16] turn_x[47:32] | -
// m_axis  | out | frame_byte[7:0]                     | last_byte
// apb     | in  | regs at 0x0 0x4 0x8 0xc             | -
// sample rate is set by the frame output, one byte per cycle while
// m_axis is ready; the framer takes no sample before its last byte
// the pipeline keeps accepting while earlier samples are in flight
// reset clears all valid bits and loads the register defaults
// a stall on m_axis holds every stage, nothing lost or repeated
`timescale 1ns / 1ps
`default_nettype none
module mecanum_drive_step_period_framer #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // stick_x, stick_y, turn_x
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // frame_byte
  output logic             m_axis_tlast,   // last_byte
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import mdsp_pkg::*;
  localparam int unsigned W = 27;
  localparam int unsigned N = (CORDIC_STEPS < AtanLen) ? CORDIC_STEPS : AtanLen;

  cfg_t cfg_q;
  reg_idx_e ridx;
  assign ridx = reg_idx_e'(paddr[3:2]);
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trans_dz <= 15'd7849;
      cfg_q.turn_dz <= 15'd8689;
      cfg_q.fast <= 16'd40;
      cfg_q.slow <= 16'd65534;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_TRANS_DZ: cfg_q.trans_dz <= pwdata[14:0];
        REG_TURN_DZ: cfg_q.turn_dz <= pwdata[14:0];
        REG_FAST: cfg_q.fast <= pwdata[15:0];
        REG_SLOW: cfg_q.slow <= pwdata[15:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (ridx)
      REG_TRANS_DZ: prdata = {17'h0, cfg_q.trans_dz};
      REG_TURN_DZ: prdata = {17'h0, cfg_q.turn_dz};
      REG_FAST: prdata = {16'h0, cfg_q.fast};
      REG_SLOW: prdata = {16'h0, cfg_q.slow};
      default: prdata = '0;
    endcase
  end

  // vectoring pre-rotation
  logic [W-1:0] vx0, vy0, sx, sy;
  logic [31:0]  vz0;
  assign sx = {{3{s_axis_tdata[15]}}, s_axis_tdata[15:0], 8'h0};
  assign sy = {{3{s_axis_tdata[31]}}, s_axis_tdata[31:16], 8'h0};
  always_comb begin
    vx0 = sx; vy0 = sy; vz0 = '0;
    if (sx[W-1]) begin
      if (!sy[W-1]) begin vx0 = sy; vy0 = -sx; vz0 = QuarterTurn; end
      else begin vx0 = -sy; vy0 = sx; vz0 = -QuarterTurn; end
    end
  end

  logic [N:0]             vv, vr;
  logic [N:0][W-1:0]      vx, vy;
  logic [N:0][31:0]       vz;
  logic [N:0][15:0]       vt;
  assign vv[0] = s_axis_tvalid;
  assign s_axis_tready = vr[0];
  assign vx[0] = vx0; assign vy[0] = vy0; assign vz[0] = vz0;
  assign vt[0] = s_axis_tdata[47:32];
  for (genvar i = 0; i < N; i++) begin : g_vec
    mdsp_cordic_stage #(.Shift(i), .Width(W), .SideW(16), .Rotate(1'b0)) u_stg (
      .clk_i, .rst_ni, .valid_i(vv[i]), .ready_o(vr[i]),
      .x_i(vx[i]), .y_i(vy[i]), .z_i(vz[i]), .side_i(vt[i]),
      .valid_o(vv[i+1]), .ready_i(vr[i+1]),
      .x_o(vx[i+1]), .y_o(vy[i+1]), .z_o(vz[i+1]), .side_o(vt[i+1]));
  end

  // stage a: gain multiply, turn abs
  logic        a_v_q, a_rdy;
  logic [44:0] a_prod_q;
  logic [31:0] a_z_q;
  logic [14:0] a_ar_q;
  logic        a_neg_q, a_rz_q;
  logic [15:0] ar_full;
  assign ar_full = vt[N][15] ? -vt[N] : vt[N];
  assign vr[N] = !a_v_q || a_rdy;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_v_q <= 1'b0;
    else if (vr[N]) a_v_q <= vv[N];
  end
  always_ff @(posedge clk_i) begin
    if (vr[N] && vv[N]) begin
      a_prod_q <= 45'($signed(vx[N][W-1] ? {W{1'b0}} : vx[N]) * $signed({1'b0, InvGain}));
      a_z_q <= vz[N];
      a_ar_q <= (ar_full > 16'd32767) ? 15'h7FFF : ar_full[14:0];
      a_neg_q <= vt[N][15];
      a_rz_q <= (ar_full < {1'b0, cfg_q.turn_dz});
    end
  end

  // stage b: magnitude cap, dead-zone flags, numerators and divisors
  logic        b_v_q, b_rdy;
  logic [29:0] b_ln_q, b_rn_q;
  logic [15:0] b_ld_q, b_rd_q;
  logic        b_lz_q, b_rz_q, b_neg_q;
  logic [31:0] b_z_q;
  logic [20:0] mag_raw;
  logic [14:0] mag;
  logic        in_dz;
  assign mag_raw = a_prod_q[44:24];
  assign mag = (mag_raw > 21'd32767) ? 15'h7FFF : mag_raw[14:0];
  assign in_dz = mag < cfg_q.trans_dz;
  assign a_rdy = !b_v_q || b_rdy;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_v_q <= 1'b0;
    else if (a_rdy) b_v_q <= a_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (a_rdy && a_v_q) begin
      b_ln_q <= {15'(mag - cfg_q.trans_dz), 15'h0};
      b_ld_q <= 16'(16'd32767 - {1'b0, cfg_q.trans_dz});
      b_lz_q <= in_dz || mag == cfg_q.trans_dz;
      b_rn_q <= {15'(a_ar_q - cfg_q.turn_dz), 15'h0};
      b_rd_q <= 16'(16'd32767 - {1'b0, cfg_q.turn_dz});
      b_rz_q <= a_rz_q || a_ar_q == cfg_q.turn_dz;
      b_neg_q <= a_neg_q;
      b_z_q <= in_dz ? 32'h0 : a_z_q;
    end
  end

  // scale quotient units, shared divider form for both sticks
  logic [1:0]       sv, sr;
  logic [1:0][47:0] sq;
  logic [1:0][34:0] ss;
  logic             s_rdy;
  assign b_rdy = sr[0] && sr[1];
  mdsp_period_div #(.SideW(35)) u_ldiv (
    .clk_i, .rst_ni, .valid_i(b_v_q && b_rdy), .ready_o(sr[0]),
    .num_i({18'h0, b_ln_q}), .den_i({17'h0, b_ld_q}),
    .side_i({b_z_q, b_lz_q, b_neg_q, b_rz_q}),
    .valid_o(sv[0]), .ready_i(s_rdy), .quo_o(sq[0]), .side_o(ss[0]));
  mdsp_period_div #(.SideW(35)) u_rdiv (
    .clk_i, .rst_ni, .valid_i(b_v_q && b_rdy), .ready_o(sr[1]),
    .num_i({18'h0, b_rn_q}), .den_i({17'h0, b_rd_q}),
    .side_i(35'h0),
    .valid_o(sv[1]), .ready_i(s_rdy), .quo_o(sq[1]), .side_o(ss[1]));

  // stage c: saturate, build rotation start
  logic        c_v_q, c_rdy;
  logic [15:0] c_l_q;
  logic signed [15:0] c_r_q;
  logic [31:0] c_z_q;
  logic [14:0] lq, rq;
  assign lq = (ss[0][2] || sq[0] > 48'd32767) ? (ss[0][2] ? 15'h0 : 15'h7FFF) : sq[0][14:0];
  assign rq = (ss[0][0] || sq[1] > 48'd32767) ? (ss[0][0] ? 15'h0 : 15'h7FFF) : sq[1][14:0];
  assign s_rdy = !c_v_q || c_rdy;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_v_q <= 1'b0;
    else if (s_rdy) c_v_q <= sv[0];
  end
  always_ff @(posedge clk_i) begin
    if (s_rdy && sv[0]) begin
      c_l_q <= {1'b0, lq};
      c_r_q <= ss[0][1] ? -$signed({3'b0, rq[14:2]}) : $signed({3'b0, rq[14:2]});
      c_z_q <= ss[0][34:3] + EighthTurn;
    end
  end

  // stage d: rotation gain
  logic        d_v_q, d_rdy;
  logic [W-1:0] d_x_q;
  logic [31:0] d_z_q;
  logic signed [15:0] d_r_q;
  logic [39:0] lg;
  assign lg = 40'({c_l_q, 8'h0}) * 40'(InvGain);
  assign c_rdy = !d_v_q || d_rdy;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) d_v_q <= 1'b0;
    else if (c_rdy) d_v_q <= c_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (c_rdy && c_v_q) begin
      d_x_q <= W'(lg[39:16]);
      d_z_q <= c_z_q;
      d_r_q <= c_r_q;
    end
  end

  logic [W-1:0] rx0, ry0;
  logic [31:0]  rz0;
  always_comb begin
    rx0 = d_x_q; ry0 = '0; rz0 = d_z_q;
    if ($signed(d_z_q) > $signed(QuarterTurn)) begin
      ry0 = d_x_q; rx0 = '0; rz0 = d_z_q - QuarterTurn;
    end else if ($signed(d_z_q) < -$signed(QuarterTurn)) begin
      ry0 = -d_x_q; rx0 = '0; rz0 = d_z_q + QuarterTurn;
    end
  end

  logic [N:0]             rv, rr;
  logic [N:0][W-1:0]      rx, ry;
  logic [N:0][31:0]       rz;
  logic [N:0][15:0]       rt;
  assign rv[0] = d_v_q;
  assign d_rdy = rr[0];
  assign rx[0] = rx0; assign ry[0] = ry0; assign rz[0] = rz0;
  assign rt[0] = d_r_q;
  for (genvar i = 0; i < N; i++) begin : g_rot
    mdsp_cordic_stage #(.Shift(i), .Width(W), .SideW(16), .Rotate(1'b1)) u_stg (
      .clk_i, .rst_ni, .valid_i(rv[i]), .ready_o(rr[i]),
      .x_i(rx[i]), .y_i(ry[i]), .z_i(rz[i]), .side_i(rt[i]),
      .valid_o(rv[i+1]), .ready_i(rr[i+1]),
      .x_o(rx[i+1]), .y_o(ry[i+1]), .z_o(rz[i+1]), .side_o(rt[i+1]));
  end

  // stage e: wheel mix, times 4
  logic        e_v_q, e_rdy;
  logic [3:0][20:0] e_t_q;
  logic signed [18:0] cc, ssn, rr16;
  assign cc = 19'($signed(rx[N]) >>> 8);
  assign ssn = 19'($signed(ry[N]) >>> 8);
  assign rr16 = 19'($signed(rt[N]));
  assign rr[N] = !e_v_q || e_rdy;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) e_v_q <= 1'b0;
    else if (rr[N]) e_v_q <= rv[N];
  end
  always_ff @(posedge clk_i) begin
    if (rr[N] && rv[N]) begin
      e_t_q[0] <= 21'(cc + rr16) <<< 2;
      e_t_q[1] <= 21'(ssn + rr16) <<< 2;
      e_t_q[2] <= 21'(ssn - rr16) <<< 2;
      e_t_q[3] <= 21'(cc - rr16) <<< 2;
    end
  end

  // stage f: divide by 5 via reciprocal, truncate toward zero
  logic        f_v_q, f_rdy;
  logic [3:0][15:0] f_av_q;
  logic [3:0]  f_nz_q, f_neg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) f_v_q <= 1'b0;
    else if (e_rdy) f_v_q <= e_v_q;
  end
  assign e_rdy = !f_v_q || f_rdy;
  always_ff @(posedge clk_i) begin
    if (e_rdy && e_v_q) begin
      for (int k = 0; k < 4; k++) begin
        logic [20:0] a;
        logic [41:0] p;
        logic [20:0] q;
        a = e_t_q[k][20] ? -e_t_q[k] : e_t_q[k];
        p = 42'(a) * 42'd838861;
        q = 21'(p >> 22);
        if (42'(q) * 42'd5 > 42'(a)) q = q - 21'd1;
        f_neg_q[k] <= e_t_q[k][20] && q != 0;
        f_nz_q[k] <= q != 0;
        f_av_q[k] <= (q > 21'd32768) ? OneQ15 : q[15:0];
      end
    end
  end

  // stage g: period numerators and divisors
  logic        g_v_q, g_rdy;
  logic [3:0][32:0] g_den_q;
  logic [47:0] g_num_q;
  logic [3:0]  g_nz_q, g_dir_q;
  assign f_rdy = !g_v_q || g_rdy;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) g_v_q <= 1'b0;
    else if (f_rdy) g_v_q <= f_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (f_rdy && f_v_q) begin
      g_num_q <= {1'b0, 32'(cfg_q.fast) * 32'(cfg_q.slow), 15'h0};
      for (int k = 0; k < 4; k++) begin
        g_den_q[k] <= 33'(32'(f_av_q[k]) * 32'(cfg_q.slow))
          + 33'(32'(OneQ15 - f_av_q[k]) * 32'(cfg_q.fast));
        g_nz_q[k] <= f_nz_q[k];
      end
      g_dir_q <= {f_neg_q[3], !f_neg_q[2], !f_neg_q[1], f_neg_q[0]};
    end
  end

  logic [3:0]        pv, pr;
  logic [3:0][47:0]  pq;
  logic [3:0][4:0]   ps;
  logic              p_rdy;
  assign g_rdy = &pr;
  for (genvar k = 0; k < 4; k++) begin : g_pdiv
    mdsp_period_div #(.SideW(5)) u_pdiv (
      .clk_i, .rst_ni, .valid_i(g_v_q && g_rdy), .ready_o(pr[k]),
      .num_i(g_num_q), .den_i(g_den_q[k]),
      .side_i({g_dir_q[k], g_nz_q}),
      .valid_o(pv[k]), .ready_i(p_rdy), .quo_o(pq[k]), .side_o(ps[k]));
  end

  // an all-ones quotient only comes from a zero divisor
  function automatic logic g_den_zero(input logic [47:0] q);
    return q == 48'hFFFF_FFFF_FFFF;
  endfunction

  logic [63:0] per;
  logic [3:0]  dir;
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (!ps[0][k]) per[16*k +: 16] = StopCode;
      else if (g_den_zero(pq[k])) per[16*k +: 16] = 16'h0;
      else per[16*k +: 16] = pq[k][15:0];
      dir[k] = ps[k][4];
    end
  end

  mdsp_framer u_framer (
    .clk_i, .rst_ni, .valid_i(pv[0]), .ready_o(p_rdy),
    .per_i(per), .dir_i(dir),
    .valid_o(m_axis_tvalid), .ready_i(m_axis_tready),
    .byte_o(m_axis_tdata), .last_o(m_axis_tlast));
endmodule
`default_nettype wire

>>> hdl/mdsp_checker.sv
// port-level checker for the mecanum drive framer
`timescale 1ns / 1ps
`default_nettype none
`include "mecanum_drive_step_period_framer_defines.svh"
module mdsp_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tlast,
  input wire logic       pready
);
  `MDF_ASSERT_NXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled byte changed")
  `MDF_ASSERT_NXT(a_last_next, clk_i, rst_ni, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid || m_axis_tdata == 8'h00, "frame must start with zero")
  `MDF_ASSERT_IMP(a_pready, clk_i, rst_ni, 1'b1, pready, "pready low")
endmodule
bind mecanum_drive_step_period_framer mdsp_checker u_chk (
  .clk_i, .rst_ni, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
  .m_axis_tlast, .pready);
`default_nettype wire
